[rtl/core/fbpa_pkg.sv]
`default_nettype none

package fbpa_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_BLOCKS_DEF = 256;
	localparam int ADDR_WIDTH_DEF = 32;

	// Register widths and reset values.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int BASE_W = 32;
	localparam int BYTES_W = 16;
	localparam int TOTAL_W = 9;

	localparam logic [BASE_W-1:0] POOL_BASE_RST = 32'd4096;
	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd4;
	localparam logic [TOTAL_W-1:0] BLOCK_TOTAL_RST = 9'd1;

	// A block must be able to hold at least one pointer.
	localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 16'd4;

	localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_TOTAL = 2'd2;

	typedef enum logic [1:0] {
		FUNC_ACQUIRE  = 2'd0,
		FUNC_RELEASE  = 2'd1,
		FUNC_REBUILD  = 2'd2,
		FUNC_CONTAINS = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_ALL_FREE = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_MUL,
		S_ADD,
		S_CHK,
		S_DIV,
		S_PUSH,
		S_REB,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

[rtl/core/fixed_block_pool_allocator_top.sv]
// Fixed-size block pool allocator.
// The input channel (in_valid, in_stall, func, address) carries one request per
// transaction: acquire, release, rebuild of the free list, or a contains query.
// The output channel (out_valid, out_stall, block_address, status, belongs,
// free_blocks) returns exactly one result transaction per request, in order.
// Geometry is set through the write port (cfg_wen, cfg_index, cfg_wdata); the user
// must write it only while idle, as the block does not enforce this. Requests are
// handled one at a time by a small sequencer around the free-index stack memory.
// An acquire passes through stack read, index multiply, base add and output, or goes
// straight to the output on an empty pool. Release and contains take one quotient
// bit per cycle in the shared restoring divider that checks block alignment, or go
// straight to the output for an address outside the pool. A new request is taken
// the cycle after the previous result has been loaded into the output register.
// A rebuild only resets the free level and the low-water mark: stack positions below
// the mark that have not been pushed since the last rebuild read as their own index.
// Reset loads the register defaults and leaves the stack as after a rebuild with one
// block, with no clearing pass. While out_stall is high the result holds in the
// output register; one further request is still accepted and finishes into a wait
// state until the output register frees up.
`default_nettype none

module fixed_block_pool_allocator_top
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
	localparam int LW = $clog2(MAX_BLOCKS + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   cfg_wen,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             func,
	input  wire logic [ADDR_WIDTH-1:0]  address,

	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [ADDR_WIDTH-1:0]       block_address,
	output logic [1:0]                  status,
	output logic                        belongs,
	output logic [LW-1:0]               free_blocks
);

	localparam int AW = ADDR_WIDTH;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int SPW = LW + BYTES_W;
	localparam int CW = (AW > SPW) ? AW : SPW;
	localparam int TW = (LW > TOTAL_W) ? LW : TOTAL_W;
	localparam int DW = IW + BYTES_W;
	localparam int PW = IW + BYTES_W;
	localparam int CNTW = $clog2(IW + 1);

	// Configuration registers.
	logic [BASE_W-1:0]  pool_base_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic [TOTAL_W-1:0] block_total_q;

	// Control state.
	state_t          state_q, state_d;
	logic [LW-1:0]   free_level_q;
	logic [LW-1:0]   low_mark_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;

	// Payload registers.
	func_t              func_q;
	logic [AW-1:0]      addr_q;
	logic [SPW-1:0]     span_q;
	logic [SPW-1:0]     rem_q;
	logic [DW-1:0]      div_q;
	logic [IW-1:0]      quo_q;
	logic [IW-1:0]      rd_q;
	logic [PW-1:0]      prod_q;
	logic [AW-1:0]      res_addr_q;
	status_t            res_status_q;
	logic               res_belongs_q;
	logic [AW-1:0]      out_addr_q;
	status_t            out_status_q;
	logic               out_belongs_q;
	logic [LW-1:0]      out_free_q;

	// Free-index stack.
	logic [IW-1:0] stack_mem [MAX_BLOCKS];

	logic [LW-1:0]      eff_total_c;
	logic [BYTES_W-1:0] eff_bytes_c;
	logic [AW-1:0]      base_c;
	logic [AW-1:0]      off_c;
	logic               chk_ok_c;
	logic               div_ge_c;
	logic               aligned_c;
	logic               push_ok_c;
	logic [IW-1:0]      acq_idx_c;
	logic [IW-1:0]      rd_addr_c;
	logic [IW-1:0]      wr_addr_c;
	logic               in_accept_c;
	logic               mem_we_c;
	logic               out_load_c;

	// Geometry after clamping.
	always_comb begin
		if (TW'(block_total_q) > TW'(MAX_BLOCKS)) begin
			eff_total_c = LW'(MAX_BLOCKS);
		end else begin
			eff_total_c = LW'(block_total_q);
		end
		eff_bytes_c = (block_bytes_q < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes_q;
	end

	// Address checks and divider step.
	always_comb begin
		base_c = AW'(pool_base_q);
		off_c = addr_q - base_c;
		chk_ok_c = (addr_q != '0) && (addr_q >= base_c) && (CW'(off_c) < CW'(span_q));
		div_ge_c = rem_q >= SPW'(div_q);
		aligned_c = (rem_q == '0);
		push_ok_c = (func_q == FUNC_RELEASE) && aligned_c && (free_level_q < eff_total_c);
		// Positions below the low-water mark still hold the rebuild contents.
		acq_idx_c = (free_level_q < low_mark_q) ? free_level_q[IW-1:0] : rd_q;
		rd_addr_c = IW'(free_level_q - LW'(1));
		wr_addr_c = free_level_q[IW-1:0];
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = (state_q != S_IDLE);
		in_accept_c = in_valid && (state_q == S_IDLE);
		mem_we_c = (state_q == S_PUSH) && push_ok_c;
		out_load_c = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept_c) begin
					unique case (func_t'(func))
						FUNC_ACQUIRE:  state_d = (free_level_q == '0) ? S_FIN : S_POP;
						FUNC_RELEASE:  state_d = S_CHK;
						FUNC_REBUILD:  state_d = S_REB;
						FUNC_CONTAINS: state_d = S_CHK;
						default:       state_d = S_IDLE;
					endcase
				end
			end
			S_POP:  state_d = S_MUL;
			S_MUL:  state_d = S_ADD;
			S_ADD:  state_d = S_FIN;
			S_CHK:  state_d = chk_ok_c ? S_DIV : S_FIN;
			S_DIV:  state_d = (cnt_q == '0) ? S_PUSH : S_DIV;
			S_PUSH: state_d = S_FIN;
			S_REB:  state_d = S_FIN;
			S_FIN:  state_d = out_load_c ? S_IDLE : S_FIN;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= POOL_BASE_RST;
			block_bytes_q <= BLOCK_BYTES_RST;
			block_total_q <= BLOCK_TOTAL_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_POOL_BASE:   pool_base_q <= cfg_wdata[BASE_W-1:0];
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata[BYTES_W-1:0];
				CFG_BLOCK_TOTAL: block_total_q <= cfg_wdata[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_level_q <= LW'(BLOCK_TOTAL_RST);
			low_mark_q <= LW'(MAX_BLOCKS);
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_POP) begin
				free_level_q <= free_level_q - LW'(1);
			end
			if (state_q == S_REB) begin
				free_level_q <= eff_total_c;
				low_mark_q <= LW'(MAX_BLOCKS);
			end
			if (mem_we_c) begin
				free_level_q <= free_level_q + LW'(1);
				if (free_level_q < low_mark_q) begin
					low_mark_q <= free_level_q;
				end
			end
			if (state_q == S_CHK) begin
				cnt_q <= CNTW'(IW - 1);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		span_q <= SPW'(eff_total_c) * SPW'(eff_bytes_c);
		if (in_accept_c) begin
			func_q <= func_t'(func);
			addr_q <= address;
			res_addr_q <= '0;
			res_belongs_q <= 1'b0;
			if ((func_t'(func) == FUNC_ACQUIRE) && (free_level_q == '0)) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= PW'(acq_idx_c) * PW'(eff_bytes_c);
		end
		if (state_q == S_ADD) begin
			res_addr_q <= base_c + AW'(prod_q);
		end
		if (state_q == S_CHK) begin
			rem_q <= SPW'(off_c);
			div_q <= DW'(eff_bytes_c) << (IW - 1);
			quo_q <= '0;
			if (!chk_ok_c && (func_q == FUNC_RELEASE)) begin
				res_status_q <= ST_INVALID;
			end
		end
		if (state_q == S_DIV) begin
			if (div_ge_c) begin
				rem_q <= rem_q - SPW'(div_q);
			end
			quo_q <= (quo_q << 1) | IW'(div_ge_c);
			div_q <= div_q >> 1;
		end
		if (state_q == S_PUSH) begin
			res_belongs_q <= aligned_c;
			if (func_q == FUNC_RELEASE) begin
				if (!aligned_c) begin
					res_status_q <= ST_INVALID;
				end else if (free_level_q >= eff_total_c) begin
					res_status_q <= ST_ALL_FREE;
				end
			end
		end
		if (out_load_c) begin
			out_addr_q <= res_addr_q;
			out_status_q <= res_status_q;
			out_belongs_q <= res_belongs_q;
			out_free_q <= free_level_q;
		end
	end

	// Stack memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we_c) begin
			stack_mem[wr_addr_c] <= quo_q;
		end
		rd_q <= stack_mem[rd_addr_c];
	end

	assign out_valid = out_valid_q;
	assign block_address = out_addr_q;
	assign status = out_status_q;
	assign belongs = out_belongs_q;
	assign free_blocks = out_free_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_level_q <= LW'(MAX_BLOCKS))
		else $error("free level exceeds the stack depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we_c |-> (free_level_q < eff_total_c))
		else $error("push into a full pool");

	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> (free_level_q == $past(free_level_q) - LW'(1)))
		else $error("acquire did not lower the free level by one");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (free_level_q != '0))
		else $error("pop from an empty stack");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && (cnt_q == '0)) |=> (state_q == S_PUSH))
		else $error("divider did not finish after its last quotient bit");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load_c)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
